[rtl/core/mqtt_control_packet_parser_defines.svh]
// Assertion helpers for the MQTT parser.
`ifndef MQTT_CONTROL_PACKET_PARSER_DEFINES_SVH
`define MQTT_CONTROL_PACKET_PARSER_DEFINES_SVH

// Assert an implication under synchronous reset.
`define MQP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Assert a next-cycle implication under synchronous reset.
`define MQP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/mqp_pkg.sv]
package mqp_pkg;

    localparam int PhW = 5;

    typedef enum logic [PhW-1:0] {
        PH_HDR      = 5'd0,
        PH_LEN      = 5'd1,
        PH_NAME     = 5'd2,
        PH_LEVEL    = 5'd3,
        PH_CFLAGS   = 5'd4,
        PH_KEEP     = 5'd5,
        PH_PROPS    = 5'd6,
        PH_CLIENT   = 5'd7,
        PH_WPROPS   = 5'd8,
        PH_WTOPIC   = 5'd9,
        PH_WMSG     = 5'd10,
        PH_USER     = 5'd11,
        PH_PASS     = 5'd12,
        PH_ACKFLAGS = 5'd13,
        PH_CODE     = 5'd14,
        PH_TOPIC    = 5'd15,
        PH_ID       = 5'd16,
        PH_QOS      = 5'd17,
        PH_PAYLOAD  = 5'd18,
        PH_RCODE    = 5'd19,
        PH_SUBCODE  = 5'd20
    } t_phase;

    typedef enum logic [1:0] {
        CLS_FIXED  = 2'd0,
        CLS_STRING = 2'd1,
        CLS_PROPS  = 2'd2,
        CLS_PAY    = 2'd3
    } t_class;

    localparam logic [4:0] K_HEADER   = 5'd0;
    localparam logic [4:0] K_LENGTH   = 5'd1;
    localparam logic [4:0] K_PROPLEN  = 5'd6;
    localparam logic [4:0] K_PROP     = 5'd7;
    localparam logic [4:0] K_CLIENTID = 5'd8;
    localparam logic [4:0] K_CODE     = 5'd14;
    localparam logic [4:0] K_PAYLOAD  = 5'd18;

    localparam logic [3:0] T_CONNECT   = 4'd1;
    localparam logic [3:0] T_CONNACK   = 4'd2;
    localparam logic [3:0] T_PUBLISH   = 4'd3;
    localparam logic [3:0] T_PUBACK    = 4'd4;
    localparam logic [3:0] T_PUBREC    = 4'd5;
    localparam logic [3:0] T_PUBREL    = 4'd6;
    localparam logic [3:0] T_PUBCOMP   = 4'd7;
    localparam logic [3:0] T_SUBSCRIBE = 4'd8;
    localparam logic [3:0] T_SUBACK    = 4'd9;
    localparam logic [3:0] T_UNSUB     = 4'd10;
    localparam logic [3:0] T_UNSUBACK  = 4'd11;

    localparam logic [7:0] LEVEL_RESET = 8'd4;
    localparam logic [7:0] LEVEL_PROPS = 8'd5;

    function automatic t_class phase_class(input t_phase ph);
        case (ph)
            PH_NAME, PH_CLIENT, PH_WTOPIC, PH_WMSG, PH_USER, PH_PASS, PH_TOPIC:
                phase_class = CLS_STRING;
            PH_PROPS, PH_WPROPS:
                phase_class = CLS_PROPS;
            PH_LEVEL, PH_CFLAGS, PH_KEEP, PH_ACKFLAGS, PH_CODE, PH_ID, PH_QOS,
            PH_RCODE, PH_SUBCODE:
                phase_class = CLS_FIXED;
            default:
                phase_class = CLS_PAY;
        endcase
    endfunction

    function automatic logic [4:0] phase_kind(input t_phase ph);
        case (ph)
            PH_CLIENT:             phase_kind = K_CLIENTID;
            PH_WPROPS:             phase_kind = K_PROPLEN;
            PH_RCODE, PH_SUBCODE:  phase_kind = K_CODE;
            PH_HDR, PH_LEN, PH_NAME, PH_LEVEL, PH_CFLAGS, PH_KEEP, PH_PROPS,
            PH_WTOPIC, PH_WMSG, PH_USER, PH_PASS, PH_ACKFLAGS, PH_CODE,
            PH_TOPIC, PH_ID, PH_QOS, PH_PAYLOAD:
                phase_kind = 5'(ph);
            default:               phase_kind = K_PAYLOAD;
        endcase
    endfunction

    function automatic t_phase after_will(input logic [7:0] cf);
        if (cf[7])      after_will = PH_USER;
        else if (cf[6]) after_will = PH_PASS;
        else            after_will = PH_PAYLOAD;
    endfunction

    function automatic t_phase following(input t_phase ph, input logic [3:0] t,
                                         input logic [3:0] fl, input logic [7:0] cf,
                                         input logic l5);
        logic id_ack;
        id_ack = (t inside {[T_PUBACK:T_PUBCOMP]}) || (t == T_UNSUBACK);
        case (ph)
            PH_LEN: begin
                if (t == T_CONNECT)                      following = PH_NAME;
                else if (t == T_CONNACK)                 following = PH_ACKFLAGS;
                else if (t == T_PUBLISH)                 following = PH_TOPIC;
                else if (t inside {[T_PUBACK:T_UNSUBACK]}) following = PH_ID;
                else                                     following = PH_PAYLOAD;
            end
            PH_NAME:   following = PH_LEVEL;
            PH_LEVEL:  following = PH_CFLAGS;
            PH_CFLAGS: following = PH_KEEP;
            PH_KEEP:   following = l5 ? PH_PROPS : PH_CLIENT;
            PH_PROPS: begin
                if (t == T_CONNECT)                        following = PH_CLIENT;
                else if (t == T_SUBSCRIBE || t == T_UNSUB) following = PH_TOPIC;
                else if (t == T_SUBACK)                    following = PH_SUBCODE;
                else                                       following = PH_PAYLOAD;
            end
            PH_CLIENT: begin
                if (cf[2]) following = l5 ? PH_WPROPS : PH_WTOPIC;
                else       following = after_will(cf);
            end
            PH_WPROPS:   following = PH_WTOPIC;
            PH_WTOPIC:   following = PH_WMSG;
            PH_WMSG:     following = after_will(cf);
            PH_USER:     following = cf[6] ? PH_PASS : PH_PAYLOAD;
            PH_ACKFLAGS: following = PH_CODE;
            PH_CODE:     following = l5 ? PH_PROPS : PH_PAYLOAD;
            PH_TOPIC: begin
                if (t == T_PUBLISH) begin
                    if (fl[2:1] != 2'd0) following = PH_ID;
                    else                 following = l5 ? PH_PROPS : PH_PAYLOAD;
                end else if (t == T_SUBSCRIBE) begin
                    following = PH_QOS;
                end else begin
                    following = PH_TOPIC;
                end
            end
            PH_ID: begin
                if (t == T_PUBLISH)   following = l5 ? PH_PROPS : PH_PAYLOAD;
                else if (id_ack)      following = l5 ? PH_RCODE : PH_PAYLOAD;
                else if (l5)          following = PH_PROPS;
                else                  following = (t == T_SUBACK) ? PH_SUBCODE : PH_TOPIC;
            end
            PH_RCODE:   following = PH_PROPS;
            PH_QOS:     following = PH_TOPIC;
            PH_SUBCODE: following = PH_SUBCODE;
            default:    following = PH_PAYLOAD;
        endcase
    endfunction

endpackage

[rtl/core/mqtt_control_packet_parser.sv]
// MQTT control packet parser: one byte in, one tagged byte out.
// Each taken input beat appears at the output in the next cycle (one result register).
// Throughput: one beat per cycle while the output is not stalled; the tagging state updates in a single step.
// A full output register is refilled in the same cycle it is taken.
// Reset (i_rst_n low, synchronous): parser awaits a fixed header, level register is 4.
module mqtt_control_packet_parser #(
    parameter int MAX_VARINT_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic [4:0]  o_field_kind,
    output logic        o_length_prefix,
    output logic        o_field_last,
    output logic [3:0]  o_packet_type,
    output logic [3:0]  o_packet_flags,
    output logic [27:0] o_remaining_length,
    output logic        o_packet_last,
    output logic        o_malformed,
    output logic        o_truncated
);
    import mqp_pkg::*;
    `include "mqtt_control_packet_parser_defines.svh"

    localparam logic [1:0] VarLast = 2'(MAX_VARINT_BYTES - 1);

    logic [7:0]  r_level_cfg;
    t_phase      r_phase, n_phase;
    logic [3:0]  r_type, n_type, r_flags, n_flags;
    logic [27:0] r_accum, n_accum, r_left, n_left, r_fleft, n_fleft, r_pkt_len, n_pkt_len;
    logic [1:0]  r_vcnt, n_vcnt, r_sub, n_sub;
    logic [7:0]  r_cflags, n_cflags, r_level, n_level;

    logic        r_valid;
    logic [7:0]  r_byte;
    logic [4:0]  r_kind, n_kind;
    logic        r_prefix, n_prefix, r_flast, n_flast, r_plast, n_plast;
    logic        r_bad, n_bad, r_trunc, n_trunc;
    logic [27:0] r_rlen, n_rlen;

    logic        take;
    logic [27:0] va_sum;
    logic        va_cont, va_bad;
    logic        l5, done, enter_next;
    t_class      cls;
    t_phase      nxt;

    assign o_stall = r_valid && i_stall;
    assign take    = i_valid && !o_stall;

    assign va_sum  = r_accum + (28'(i_in_byte[6:0]) << (5'd7 * 5'(r_vcnt)));
    assign va_cont = i_in_byte[7];
    assign va_bad  = va_cont && (r_vcnt >= VarLast);
    assign l5      = r_level >= LEVEL_PROPS;
    assign cls     = phase_class(r_phase);
    assign nxt     = following(r_phase, r_type, r_flags, r_cflags, l5);

    always_comb begin
        n_phase = r_phase; n_type = r_type; n_flags = r_flags; n_accum = r_accum;
        n_left = r_left; n_fleft = r_fleft; n_pkt_len = r_pkt_len; n_vcnt = r_vcnt;
        n_sub = r_sub; n_cflags = r_cflags; n_level = r_level;
        n_kind = K_HEADER; n_prefix = 1'b0; n_flast = 1'b0; n_plast = 1'b0;
        n_bad = 1'b0; n_trunc = 1'b0; n_rlen = r_pkt_len;
        done = 1'b0; enter_next = 1'b0;
        if (r_phase == PH_HDR) begin
            n_type = i_in_byte[7:4]; n_flags = i_in_byte[3:0];
            n_level = r_level_cfg; n_pkt_len = '0; n_rlen = '0; n_flast = 1'b1;
            n_phase = PH_LEN; n_accum = '0; n_vcnt = '0;
        end else if (r_phase == PH_LEN) begin
            n_kind = K_LENGTH; n_accum = va_sum; n_rlen = va_sum;
            if (va_bad) begin
                n_bad = 1'b1; n_phase = PH_HDR;
            end else if (va_cont) begin
                n_vcnt = r_vcnt + 2'd1;
            end else begin
                n_flast = 1'b1; n_pkt_len = va_sum; n_left = va_sum;
                if (va_sum == '0) begin
                    n_plast = 1'b1; n_phase = PH_HDR;
                end else begin
                    enter_next = 1'b1;
                end
            end
        end else begin
            n_left  = r_left - 28'd1;
            n_plast = (n_left == '0);
            n_kind  = phase_kind(r_phase);
            case (cls)
                CLS_FIXED: begin
                    if (r_phase == PH_LEVEL)  n_level  = i_in_byte;
                    if (r_phase == PH_CFLAGS) n_cflags = i_in_byte;
                    n_fleft = r_fleft - 28'd1;
                    done = (n_fleft == '0);
                    n_flast = done;
                end
                CLS_STRING: begin
                    n_prefix = (r_sub != 2'd2);
                    if (r_sub == 2'd0) begin
                        n_fleft = {12'd0, i_in_byte, 8'd0}; n_sub = 2'd1;
                    end else if (r_sub == 2'd1) begin
                        n_fleft = r_fleft | 28'(i_in_byte);
                        if (n_fleft == '0) done = 1'b1;
                        else n_sub = 2'd2;
                    end else begin
                        n_fleft = r_fleft - 28'd1;
                        done = (n_fleft == '0);
                    end
                    n_flast = done;
                end
                CLS_PROPS: begin
                    if (r_sub == 2'd0) begin
                        n_kind = K_PROPLEN; n_accum = va_sum;
                        if (va_bad) begin
                            n_bad = 1'b1;
                        end else if (va_cont) begin
                            n_vcnt = r_vcnt + 2'd1;
                        end else begin
                            n_flast = 1'b1;
                            if (va_sum == '0) done = 1'b1;
                            else begin
                                n_fleft = va_sum; n_sub = 2'd2;
                            end
                        end
                    end else begin
                        n_kind = K_PROP;
                        n_fleft = r_fleft - 28'd1;
                        done = (n_fleft == '0);
                        n_flast = done;
                    end
                end
                default: begin
                    n_flast = n_plast; done = 1'b1;
                end
            endcase
            n_trunc = n_plast && !done;
            if (n_bad || n_plast) n_phase = PH_HDR;
            else if (done && cls != CLS_PAY) enter_next = 1'b1;
        end
        if (enter_next) begin
            n_phase = nxt; n_sub = '0; n_accum = '0; n_vcnt = '0;
            n_fleft = (nxt == PH_KEEP || nxt == PH_ID) ? 28'd2 : 28'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_cfg <= LEVEL_RESET;
            r_phase <= PH_HDR; r_type <= '0; r_flags <= '0; r_accum <= '0;
            r_left <= '0; r_fleft <= '0; r_pkt_len <= '0; r_vcnt <= '0;
            r_sub <= '0; r_cflags <= '0; r_level <= LEVEL_RESET;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_level_cfg <= i_cfg_wdata;
            if (take) begin
                r_phase <= n_phase; r_type <= n_type; r_flags <= n_flags;
                r_accum <= n_accum; r_left <= n_left; r_fleft <= n_fleft;
                r_pkt_len <= n_pkt_len; r_vcnt <= n_vcnt; r_sub <= n_sub;
                r_cflags <= n_cflags; r_level <= n_level;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte <= i_in_byte; r_kind <= n_kind; r_prefix <= n_prefix;
            r_flast <= n_flast; r_plast <= n_plast; r_bad <= n_bad;
            r_trunc <= n_trunc; r_rlen <= n_rlen;
        end
    end

    assign o_valid            = r_valid;
    assign o_out_byte         = r_byte;
    assign o_field_kind       = r_kind;
    assign o_length_prefix    = r_prefix;
    assign o_field_last       = r_flast;
    assign o_packet_type      = r_type;
    assign o_packet_flags     = r_flags;
    assign o_remaining_length = r_rlen;
    assign o_packet_last      = r_plast;
    assign o_malformed        = r_bad;
    assign o_truncated        = r_trunc;

    `MQP_ASSERT_NXT(a_bad_resync, i_clk, i_rst_n, take && n_bad, r_phase == PH_HDR)
    `MQP_ASSERT_NXT(a_plast_resync, i_clk, i_rst_n, take && n_plast, r_phase == PH_HDR)
    `MQP_ASSERT_IMP(a_trunc_plast, i_clk, i_rst_n, r_valid && o_truncated, o_packet_last)
    `MQP_ASSERT_IMP(a_hdr_kind, i_clk, i_rst_n,
                    take && r_phase == PH_HDR, n_kind == K_HEADER && n_flast)
endmodule
